// ===== hw/rtl/dqnp_pkg.sv =====
// ----------------------------------------------------------------------------
// dqnp_pkg: shared types and constants for the DNS question name parser
// Widths, phase encoding, status and query-kind codes, item structs and the
// small decode functions used by the parse core.
// ----------------------------------------------------------------------------
package dqnp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned MSG_LEN_W  = 12;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned NAME_LEN_W = 8;
  localparam int unsigned LABEL_W    = 7;

  localparam int unsigned MAX_MESSAGE  = 2048;
  localparam int unsigned NAME_BUFFER  = 255;
  localparam int unsigned HEADER_BYTES = 12;

  // message length clamp and saturating byte position
  localparam logic [MSG_LEN_W-1:0] LEN_CLAMP  = MSG_LEN_W'(MAX_MESSAGE);
  localparam logic [MSG_LEN_W-1:0] POS_MAX    = {MSG_LEN_W{1'b1}};
  localparam logic [MSG_LEN_W-1:0] HDR_MIN    = MSG_LEN_W'(HEADER_BYTES);
  localparam logic [MSG_LEN_W-1:0] HDR_LAST   = MSG_LEN_W'(HEADER_BYTES - 1);
  localparam logic [NAME_LEN_W-1:0] NAME_LIMIT = NAME_LEN_W'(NAME_BUFFER - 1);

  localparam logic [BYTE_W-1:0] CHAR_DOT = 8'h2E;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_LABEL,
    PH_TYPE_HI,
    PH_TYPE_LO,
    PH_DONE
  } phase_t;

  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT_HEADER = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LABEL_OVERRUN = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_CHAR     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TYPE_MISSING = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NAME_LONG    = 3'd5;

  localparam logic [KIND_W-1:0] KIND_A       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_AAAA    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MX      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NS      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CNAME   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SOA     = 3'd5;
  localparam logic [KIND_W-1:0] KIND_PTR     = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd7;

  // query type numbers on the wire
  localparam logic [15:0] QT_A     = 16'd1;
  localparam logic [15:0] QT_NS    = 16'd2;
  localparam logic [15:0] QT_CNAME = 16'd5;
  localparam logic [15:0] QT_SOA   = 16'd6;
  localparam logic [15:0] QT_PTR   = 16'd12;
  localparam logic [15:0] QT_MX    = 16'd15;
  localparam logic [15:0] QT_AAAA  = 16'd28;

  typedef struct packed {
    logic [BYTE_W-1:0]    msg_byte;
    logic [MSG_LEN_W-1:0] msg_length;
    logic                 last_byte;
  } in_item_t;

  typedef struct packed {
    logic                  is_verdict;
    logic [BYTE_W-1:0]     name_char;
    logic [STATUS_W-1:0]   status;
    logic [KIND_W-1:0]     query_kind;
    logic [NAME_LEN_W-1:0] name_length;
  } out_item_t;

  // core -> output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  // letters, digits and '-'
  function automatic logic label_char_ok(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] low;
    low = c | 8'h20;
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((low >= 8'h61) && (low <= 8'h7A)) ||
           (c == 8'h2D);
  endfunction

  function automatic logic [KIND_W-1:0] kind_of(input logic [15:0] t);
    logic [KIND_W-1:0] k;
    case (t)
      QT_A:     k = KIND_A;
      QT_AAAA:  k = KIND_AAAA;
      QT_MX:    k = KIND_MX;
      QT_NS:    k = KIND_NS;
      QT_CNAME: k = KIND_CNAME;
      QT_SOA:   k = KIND_SOA;
      QT_PTR:   k = KIND_PTR;
      default:  k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// ===== hw/rtl/dqnp_in_if.sv =====
// ----------------------------------------------------------------------------
// dqnp_in_if: message byte channel
// Valid/ready channel carrying one message byte with its length and end flag.
// ----------------------------------------------------------------------------
interface dqnp_in_if;
  logic                           valid;
  logic                           ready;
  logic [dqnp_pkg::BYTE_W-1:0]    msg_byte;
  logic [dqnp_pkg::MSG_LEN_W-1:0] msg_length;
  logic                           last_byte;

  modport source (output valid, output msg_byte, output msg_length,
                  output last_byte, input ready);
  modport sink   (input valid, input msg_byte, input msg_length,
                  input last_byte, output ready);
endinterface

// ===== hw/rtl/dqnp_out_if.sv =====
// ----------------------------------------------------------------------------
// dqnp_out_if: result channel
// Valid/ready channel carrying a name character or the final verdict.
// ----------------------------------------------------------------------------
interface dqnp_out_if;
  logic                            valid;
  logic                            ready;
  logic                            is_verdict;
  logic [dqnp_pkg::BYTE_W-1:0]     name_char;
  logic [dqnp_pkg::STATUS_W-1:0]   status;
  logic [dqnp_pkg::KIND_W-1:0]     query_kind;
  logic [dqnp_pkg::NAME_LEN_W-1:0] name_length;

  modport source (output valid, output is_verdict, output name_char, output status,
                  output query_kind, output name_length, input ready);
  modport sink   (input valid, input is_verdict, input name_char, input status,
                  input query_kind, input name_length, output ready);
endinterface

// ===== hw/rtl/dqnp_in_stage.sv =====
// ----------------------------------------------------------------------------
// dqnp_in_stage: input register
// Captures one message byte; refills in the same cycle it is consumed.
// ----------------------------------------------------------------------------
module dqnp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  dqnp_in_if.sink            in_if,
  input  logic               adv,      // downstream takes the held item
  output logic               hold_valid,
  output dqnp_pkg::in_item_t hold_item
);
  import dqnp_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_if.ready = !valid_r || adv;
  assign hold_valid  = valid_r;
  assign hold_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_if.ready) begin
      valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      item_r.msg_byte   <= in_if.msg_byte;
      item_r.msg_length <= in_if.msg_length;
      item_r.last_byte  <= in_if.last_byte;
    end
  end

endmodule

// ===== hw/rtl/dqnp_core.sv =====
// ----------------------------------------------------------------------------
// dqnp_core: parse state machine
// Holds the parser state and decides, for each byte, the next state and
// whether a name character or a verdict comes out.
// ----------------------------------------------------------------------------
module dqnp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,     // held byte is consumed this cycle
  input  dqnp_pkg::in_item_t item,
  output dqnp_pkg::result_t  res
);
  import dqnp_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [MSG_LEN_W-1:0]  pos_r, pos_nxt;
  logic [LABEL_W-1:0]    rem_r, rem_nxt;
  logic [NAME_LEN_W-1:0] chars_r, chars_nxt;
  logic [BYTE_W-1:0]     type_hi_r, type_hi_nxt;

  logic [MSG_LEN_W-1:0]  len;
  logic                  beyond;
  logic [MSG_LEN_W:0]    label_end;
  logic                  verdict;
  logic [STATUS_W-1:0]   status;
  logic [KIND_W-1:0]     kind;
  logic                  emit;
  logic [BYTE_W-1:0]     emit_char;
  logic [LABEL_W-1:0]    rem_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      pos_r     <= '0;
      rem_r     <= '0;
      chars_r   <= '0;
      type_hi_r <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      rem_r     <= rem_nxt;
      chars_r   <= chars_nxt;
      type_hi_r <= type_hi_nxt;
    end
  end

  assign len       = (item.msg_length > LEN_CLAMP) ? LEN_CLAMP : item.msg_length;
  assign beyond    = pos_r >= len;
  assign label_end = {1'b0, pos_r} + {{(MSG_LEN_W + 1 - LABEL_W){1'b0}},
                                      item.msg_byte[LABEL_W-1:0]};
  assign rem_dec   = (rem_r != '0) ? rem_r - 1'b1 : '0;

  always_comb begin
    phase_nxt   = phase_r;
    rem_nxt     = rem_r;
    chars_nxt   = chars_r;
    type_hi_nxt = type_hi_r;
    pos_nxt     = (pos_r < POS_MAX) ? pos_r + 1'b1 : pos_r;
    verdict     = 1'b0;
    status      = ST_OK;
    kind        = KIND_UNKNOWN;
    emit        = 1'b0;
    emit_char   = item.msg_byte;

    unique case (phase_r)
      PH_HEADER: begin
        if (len < HDR_MIN) begin
          verdict = 1'b1;
          status  = ST_SHORT_HEADER;
        end else if (pos_r >= HDR_LAST) begin
          phase_nxt = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (beyond) begin
          verdict = 1'b1;
          status  = ST_TYPE_MISSING;
        end else if (item.msg_byte == '0) begin
          phase_nxt = PH_TYPE_HI;
        end else if (item.msg_byte[BYTE_W-1] || (label_end >= {1'b0, len})) begin
          verdict = 1'b1;
          status  = ST_LABEL_OVERRUN;
        end else if ((chars_r != '0) && (chars_r >= NAME_LIMIT)) begin
          verdict = 1'b1;
          status  = ST_NAME_LONG;
        end else begin
          // separator dot between labels
          if (chars_r != '0) begin
            emit      = 1'b1;
            emit_char = CHAR_DOT;
            chars_nxt = chars_r + 1'b1;
          end
          rem_nxt   = item.msg_byte[LABEL_W-1:0];
          phase_nxt = PH_LABEL;
        end
      end
      PH_LABEL: begin
        if (beyond || !label_char_ok(item.msg_byte)) begin
          verdict = 1'b1;
          status  = ST_BAD_CHAR;
        end else if (chars_r >= NAME_LIMIT) begin
          verdict = 1'b1;
          status  = ST_NAME_LONG;
        end else begin
          emit      = 1'b1;
          chars_nxt = chars_r + 1'b1;
          rem_nxt   = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = PH_LENGTH;
          end
        end
      end
      PH_TYPE_HI: begin
        if (beyond) begin
          verdict = 1'b1;
          status  = ST_TYPE_MISSING;
        end else begin
          type_hi_nxt = item.msg_byte;
          phase_nxt   = PH_TYPE_LO;
        end
      end
      PH_TYPE_LO: begin
        verdict = 1'b1;
        if (beyond) begin
          status = ST_TYPE_MISSING;
        end else begin
          status = ST_OK;
          kind   = kind_of({type_hi_r, item.msg_byte});
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (verdict) begin
      phase_nxt = PH_DONE;
    end

    // message ended before a verdict: close it out now
    if (item.last_byte && (phase_nxt != PH_DONE)) begin
      verdict = 1'b1;
      kind    = KIND_UNKNOWN;
      if (phase_nxt == PH_HEADER) begin
        status = ST_SHORT_HEADER;
      end else if (phase_nxt == PH_LABEL) begin
        status = ST_BAD_CHAR;
      end else begin
        status = ST_TYPE_MISSING;
      end
    end

    res.valid                 = verdict || emit;
    res.item.is_verdict       = verdict;
    res.item.name_char        = verdict ? '0 : emit_char;
    res.item.status           = verdict ? status : ST_OK;
    if (verdict) begin
      res.item.query_kind  = (status == ST_OK) ? kind : KIND_UNKNOWN;
      res.item.name_length = (status == ST_OK) ? chars_nxt : '0;
    end else begin
      res.item.query_kind  = KIND_A;
      res.item.name_length = '0;
    end

    if (item.last_byte) begin
      phase_nxt   = PH_HEADER;
      pos_nxt     = '0;
      rem_nxt     = '0;
      chars_nxt   = '0;
      type_hi_nxt = '0;
    end
  end

endmodule

// ===== hw/rtl/dqnp_out_stage.sv =====
// ----------------------------------------------------------------------------
// dqnp_out_stage: result register
// Holds one result until the consumer takes it; frees up as it drains.
// ----------------------------------------------------------------------------
module dqnp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,   // a byte is consumed this cycle
  input  dqnp_pkg::result_t res,
  output logic              adv,    // register can take a new result
  dqnp_out_if.source        out_if
);
  import dqnp_pkg::*;

  logic      valid_r;
  out_item_t item_r;

  assign adv = !valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && step && res.valid) begin
      item_r <= res.item;
    end
  end

  assign out_if.valid       = valid_r;
  assign out_if.is_verdict  = item_r.is_verdict;
  assign out_if.name_char   = item_r.name_char;
  assign out_if.status      = item_r.status;
  assign out_if.query_kind  = item_r.query_kind;
  assign out_if.name_length = item_r.name_length;

endmodule

// ===== hw/rtl/dns_question_name_parser_top.sv =====
// ----------------------------------------------------------------------------
// dns_question_name_parser_top: DNS question name parser
// Walks a DNS message byte by byte, streams the dotted question name and
// closes each message with one verdict (status, query kind, name length).
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake     carries
//   in_if    in   valid/ready   msg_byte, msg_length, last_byte
//   out_if   out  valid/ready   is_verdict, name_char, status, query_kind,
//                               name_length
//
// One byte per cycle sustained while out_if is not stalled; every byte is parsed
// combinationally between the input register and the result register, which
// holds its result. Bytes that make no result leave no bubble.
// rst_n is synchronous: the parser returns to the header phase and both
// registers empty. A stalled consumer holds the result register, which holds
// the input register, which drops in_if.ready; nothing is lost or repeated.
//
module dns_question_name_parser_top (
  input logic        clk,
  input logic        rst_n,
  dqnp_in_if.sink    in_if,
  dqnp_out_if.source out_if
);
  import dqnp_pkg::*;

  logic     hold_valid;
  in_item_t hold_item;
  logic     adv;
  logic     step;
  result_t  res;

  // held byte is parsed in the cycle the result register can take its output
  assign step = hold_valid && adv;

  dqnp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .adv        (adv),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  dqnp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (hold_item),
    .res   (res)
  );

  dqnp_out_stage u_out_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .res    (res),
    .adv    (adv),
    .out_if (out_if)
  );

endmodule
